### hw/rtl/kmer_suffix_bucketing_core_assert.svh
// Assertion macros shared by the k-mer suffix bucketing RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef KMER_SUFFIX_BUCKETING_CORE_ASSERT_SVH
`define KMER_SUFFIX_BUCKETING_CORE_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define KSB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define KSB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/ksb_pkg.sv
// Shared types, codes and constants of the k-mer suffix bucketing core.
// Depends on nothing; used by every module of the block except ksb_ram.
`default_nettype none

package ksb_pkg;

  // Default parameter values.
  localparam int KSB_ALPHABET_SIZE = 26;
  localparam int KSB_MAX_WINDOW    = 3;
  localparam int KSB_SLOT_DEPTH    = 65536;
  localparam int KSB_POSITION_BITS = 16;

  // Fixed constants.
  localparam logic [7:0]  LETTER_BASE    = 8'd65;
  localparam logic [16:0] LINK_NONE      = 17'h10000;
  localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;
  localparam logic [1:0]  KMER_LEN_RESET = 2'd3;

  // Command codes of an input transaction.
  localparam logic [1:0] CMD_PUSH        = 2'd0;
  localparam logic [1:0] CMD_READ_BUCKET = 2'd1;
  localparam logic [1:0] CMD_READ_SLOT   = 2'd2;

  // Status codes of a result transaction.
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_NO_WINDOW = 3'd1;
  localparam logic [2:0] ST_BAD       = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_READ_OK   = 3'd4;
  localparam logic [2:0] ST_RANGE     = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  symbol;
    logic        last_in_sequence;
    logic [15:0] read_index;
  } ksb_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [14:0] bucket_number;
    logic [15:0] slot_number;
    logic [16:0] link_slot;
    logic [16:0] bucket_count;
    logic [15:0] sequence_number;
    logic [15:0] start_position;
  } ksb_out_t;

  // What an accepted transaction turns out to be.
  typedef enum logic [2:0] {
    KIND_BAD,
    KIND_NO_WINDOW,
    KIND_WINDOW,
    KIND_READ_BUCKET,
    KIND_READ_SLOT,
    KIND_NOP
  } ksb_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic finish;
  } ksb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
    logic out_free;
  } ksb_stat_t;

  // Integer power, evaluated at elaboration.
  function automatic int ksb_pow(input int base, input int expo);
    int p;
    p = 1;
    for (int i = 0; i < expo; i++) begin
      p = p * base;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/ksb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; holds the bucket table and the suffix slots.
`default_nettype none

module ksb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/ksb_ctrl.sv
// Controller state machine: table clear, accept and finish sequencing.
// Depends on ksb_pkg and the assertion macro header.
`default_nettype none
`include "kmer_suffix_bucketing_core_assert.svh"

module ksb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ksb_pkg::ksb_stat_t stat,
  output ksb_pkg::ksb_cmd_t  cmd
);

  import ksb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR  = 3'b001,
    S_IDLE   = 3'b010,
    S_FINISH = 3'b100
  } ksb_state_t;

  ksb_state_t state;
  ksb_state_t state_next;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  // State register; reset starts the bucket table clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  `KSB_ASSERT_NEXT(a_accept_to_finish, clk, rst, cmd.accept, state == S_FINISH, "accept did not lead to finish")
  `KSB_ASSERT_NEXT(a_finish_holds, clk, rst, (state == S_FINISH) && !stat.out_free, state == S_FINISH, "finish left while output blocked")
  `KSB_ASSERT_NEXT(a_clear_runs, clk, rst, (state == S_CLEAR) && !stat.clear_last, !in_ready, "input accepted before clear ended")

endmodule

`default_nettype wire

### hw/rtl/ksb_datapath.sv
// Datapath: window hashing, bucket and slot memories, result register.
// Depends on ksb_pkg, ksb_ram and the assertion macro header.
`default_nettype none
`include "kmer_suffix_bucketing_core_assert.svh"

module ksb_datapath #(
  parameter int ALPHABET_SIZE = ksb_pkg::KSB_ALPHABET_SIZE,
  parameter int MAX_WINDOW    = ksb_pkg::KSB_MAX_WINDOW,
  parameter int SLOT_DEPTH    = ksb_pkg::KSB_SLOT_DEPTH,
  parameter int POSITION_BITS = ksb_pkg::KSB_POSITION_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_data,
  input  ksb_pkg::ksb_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ksb_pkg::ksb_out_t  out_data,
  input  ksb_pkg::ksb_cmd_t  cmd,
  output ksb_pkg::ksb_stat_t stat
);

  import ksb_pkg::*;

  localparam int BUCKET_DEPTH = ksb_pow(ALPHABET_SIZE, MAX_WINDOW);
  localparam int BUCKET_BITS  = $clog2(BUCKET_DEPTH);
  localparam int LIM_W        = BUCKET_BITS + 1;
  localparam int SLOT_LIMIT   = (SLOT_DEPTH < 65536) ? SLOT_DEPTH : 65536;
  localparam int SLOT_BITS    = $clog2(SLOT_LIMIT);
  localparam int NFS_W        = SLOT_BITS + 1;
  localparam int FILL_W       = $clog2(MAX_WINDOW + 1);
  localparam int BKT_W        = 34;
  localparam int SLOT_W       = 49;

  // Architectural state.
  logic [1:0]               kmer_len;
  logic [BUCKET_BITS-1:0]   lane [MAX_WINDOW];
  logic [FILL_W-1:0]        fill;
  logic [POSITION_BITS-1:0] position;
  logic [15:0]              current_sequence;
  logic [NFS_W-1:0]         next_free;
  logic [BUCKET_BITS-1:0]   clr_addr;

  // Transaction held between accept and finish.
  ksb_kind_t                kind_q;
  logic [BUCKET_BITS-1:0]   bucket_q;
  logic [15:0]              index_q;
  logic [15:0]              seq_q;
  logic [15:0]              start_q;
  logic                     rd_ok_q;

  // Accept-cycle logic.
  logic [FILL_W-1:0]        k_eff;
  logic [8:0]               diff;
  logic                     letter_ok;
  logic [4:0]               code;
  logic [BUCKET_BITS-1:0]   lane_next [MAX_WINDOW];
  logic [LIM_W-1:0]         limit_tab [MAX_WINDOW];
  logic [BUCKET_BITS-1:0]   bucket_sel;
  logic [LIM_W-1:0]         limit_sel;
  logic [FILL_W-1:0]        fill_next;
  logic                     win_full;
  logic [POSITION_BITS-1:0] start_pos;
  ksb_kind_t                kind_next;
  logic                     rd_ok_next;

  // Memory ports.
  logic                     bkt_wr_en;
  logic [BUCKET_BITS-1:0]   bkt_wr_addr;
  logic [BKT_W-1:0]         bkt_wr_data;
  logic [BUCKET_BITS-1:0]   bkt_rd_addr;
  logic [BKT_W-1:0]         bkt_rd_data;
  logic [SLOT_W-1:0]        slot_wr_data;
  logic [SLOT_W-1:0]        slot_rd_data;

  // Finish-cycle logic.
  logic [16:0]              head;
  logic [16:0]              count;
  logic [16:0]              count_inc;
  logic                     store_full;
  logic                     insert;
  ksb_out_t                 result;

  // Configuration register, always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_len <= KMER_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      kmer_len <= cfg_data;
    end
  end

  // Effective window length, clamped to one through the maximum.
  always_comb begin
    if (kmer_len == 2'd0) begin
      k_eff = FILL_W'(1);
    end else if (32'(kmer_len) > MAX_WINDOW) begin
      k_eff = FILL_W'(MAX_WINDOW);
    end else begin
      k_eff = FILL_W'(kmer_len);
    end
  end

  // Letter check and code.
  assign diff      = {1'b0, in_data.symbol} - {1'b0, LETTER_BASE};
  assign letter_ok = !diff[8] && (diff < 9'(ALPHABET_SIZE));
  assign code      = diff[4:0];

  // Each lane holds the value of the last j+1 codes; all lanes shift in parallel.
  always_comb begin
    lane_next[0] = BUCKET_BITS'(code);
    for (int j = 1; j < MAX_WINDOW; j++) begin
      lane_next[j] = BUCKET_BITS'(32'(lane[j-1]) * ALPHABET_SIZE + 32'(code));
    end
  end

  // Bucket count for each window length.
  for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_lim
    assign limit_tab[j] = LIM_W'(ksb_pow(ALPHABET_SIZE, j + 1));
  end

  // Pick the lane and limit of the effective window length.
  always_comb begin
    bucket_sel = '0;
    limit_sel  = '0;
    for (int j = 0; j < MAX_WINDOW; j++) begin
      if (k_eff == FILL_W'(j + 1)) begin
        bucket_sel = lane_next[j];
        limit_sel  = limit_tab[j];
      end
    end
  end

  // Window fill after this letter and the window start position.
  always_comb begin
    if (!letter_ok) begin
      fill_next = '0;
    end else if (fill < FILL_W'(MAX_WINDOW)) begin
      fill_next = fill + 1'b1;
    end else begin
      fill_next = fill;
    end
  end

  assign win_full  = letter_ok && (fill_next >= k_eff);
  assign start_pos = position - (POSITION_BITS'(k_eff) - POSITION_BITS'(1));

  // Classify the transaction and check read ranges.
  always_comb begin
    kind_next  = KIND_NOP;
    rd_ok_next = 1'b0;
    unique case (in_data.cmd)
      CMD_PUSH: begin
        if (!letter_ok) begin
          kind_next = KIND_BAD;
        end else if (win_full && !in_data.last_in_sequence) begin
          kind_next = KIND_WINDOW;
        end else begin
          kind_next = KIND_NO_WINDOW;
        end
      end
      CMD_READ_BUCKET: begin
        kind_next  = KIND_READ_BUCKET;
        rd_ok_next = 33'(in_data.read_index) < 33'(limit_sel);
      end
      CMD_READ_SLOT: begin
        kind_next  = KIND_READ_SLOT;
        rd_ok_next = 17'(in_data.read_index) < 17'(next_free);
      end
      default: begin
        kind_next = KIND_NOP;
      end
    endcase
  end

  // Capture the accepted transaction.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q   <= kind_next;
      bucket_q <= bucket_sel;
      index_q  <= in_data.read_index;
      seq_q    <= current_sequence;
      start_q  <= 16'(start_pos);
      rd_ok_q  <= rd_ok_next;
    end
  end

  // Window, position and sequence state advance on each pushed letter.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
        lane[j] <= '0;
      end
      fill             <= '0;
      position         <= '0;
      current_sequence <= '0;
    end else if (cmd.accept && (in_data.cmd == CMD_PUSH)) begin
      if (letter_ok) begin
        lane <= lane_next;
      end
      if (in_data.last_in_sequence) begin
        fill             <= '0;
        position         <= '0;
        current_sequence <= current_sequence + 16'd1;
      end else begin
        fill     <= fill_next;
        position <= position + POSITION_BITS'(1);
      end
    end
  end

  // Clear sweep over the bucket table after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_wr) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign stat.clear_last = (clr_addr == BUCKET_BITS'(BUCKET_DEPTH - 1));

  // Finish-cycle decisions from the registered read data.
  assign head       = bkt_rd_data[33:17];
  assign count      = bkt_rd_data[16:0];
  assign count_inc  = (count == COUNT_MAX) ? count : count + 17'd1;
  assign store_full = (next_free == NFS_W'(SLOT_LIMIT));
  assign insert     = cmd.finish && (kind_q == KIND_WINDOW) && !store_full;

  // Slot allocation counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      next_free <= '0;
    end else if (insert) begin
      next_free <= next_free + 1'b1;
    end
  end

  // Bucket table port: clear writes or head and count updates.
  assign bkt_wr_en   = cmd.clear_wr || insert;
  assign bkt_wr_addr = cmd.clear_wr ? clr_addr : bucket_q;
  assign bkt_wr_data = cmd.clear_wr ? {LINK_NONE, 17'd0} : {17'(next_free), count_inc};
  assign bkt_rd_addr = (in_data.cmd == CMD_PUSH) ? bucket_sel
                                                 : BUCKET_BITS'(in_data.read_index);

  assign slot_wr_data = {seq_q, start_q, head};

  ksb_ram #(
    .WIDTH (BKT_W),
    .DEPTH (BUCKET_DEPTH)
  ) u_bucket_ram (
    .clk     (clk),
    .wr_en   (bkt_wr_en),
    .wr_addr (bkt_wr_addr),
    .wr_data (bkt_wr_data),
    .rd_en   (cmd.accept),
    .rd_addr (bkt_rd_addr),
    .rd_data (bkt_rd_data)
  );

  ksb_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_LIMIT)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (insert),
    .wr_addr (next_free[SLOT_BITS-1:0]),
    .wr_data (slot_wr_data),
    .rd_en   (cmd.accept),
    .rd_addr (in_data.read_index[SLOT_BITS-1:0]),
    .rd_data (slot_rd_data)
  );

  // Result of the finishing transaction.
  always_comb begin
    result           = '0;
    result.link_slot = LINK_NONE;
    unique case (kind_q)
      KIND_BAD: begin
        result.status          = ST_BAD;
        result.sequence_number = seq_q;
      end
      KIND_NO_WINDOW: begin
        result.status          = ST_NO_WINDOW;
        result.sequence_number = seq_q;
      end
      KIND_WINDOW: begin
        result.bucket_number   = 15'(bucket_q);
        result.link_slot       = head;
        result.sequence_number = seq_q;
        result.start_position  = start_q;
        if (store_full) begin
          result.status       = ST_FULL;
          result.bucket_count = count;
        end else begin
          result.status       = ST_INSERTED;
          result.slot_number  = 16'(next_free);
          result.bucket_count = count_inc;
        end
      end
      KIND_READ_BUCKET: begin
        result.bucket_number = 15'(index_q);
        if (rd_ok_q) begin
          result.status       = ST_READ_OK;
          result.link_slot    = head;
          result.bucket_count = count;
        end else begin
          result.status = ST_RANGE;
        end
      end
      KIND_READ_SLOT: begin
        result.slot_number = index_q;
        if (rd_ok_q) begin
          result.status          = ST_READ_OK;
          result.link_slot       = slot_rd_data[16:0];
          result.sequence_number = slot_rd_data[48:33];
          result.start_position  = slot_rd_data[32:17];
        end else begin
          result.status = ST_RANGE;
        end
      end
      KIND_NOP: begin
        result.status = ST_NO_WINDOW;
      end
      default: begin
        result.status = ST_NO_WINDOW;
      end
    endcase
  end

  // Output register decouples the result from the next transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data <= result;
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  `KSB_ASSERT_SAME(a_slot_bound, clk, rst, 1'b1, 32'(next_free) <= SLOT_LIMIT,
                   "slot counter beyond store")
  `KSB_ASSERT_NEXT(a_slot_step, clk, rst, insert,
                   next_free == NFS_W'($past(next_free) + 1'b1), "slot counter did not step")
  `KSB_ASSERT_SAME(a_clear_alone, clk, rst, cmd.clear_wr, !cmd.accept && !cmd.finish,
                   "transaction during table clear")

endmodule

`default_nettype wire

### hw/rtl/kmer_suffix_bucketing_core.sv
// Top level of the k-mer suffix bucketing core: controller plus datapath.
// Depends on ksb_pkg, ksb_ctrl and ksb_datapath.
//
//   Channel  Dir  Handshake             Payload
//   in       in   in_valid / in_ready   in_data  (ksb_in_t)
//   out      out  out_valid / out_ready out_data (ksb_out_t)
//   cfg      in   cfg_valid / cfg_ready cfg_data (k-mer length, 2 bits)
//
// Each transaction has an accept cycle, which issues the bucket and slot memory
// reads, and a finish cycle, which uses the registered read data and writes
// back the bucket head, count and new slot.
// The finish cycle waits while the output register holds an untaken result.
// After reset the bucket table is cleared one entry per cycle; meanwhile
// in_ready stays low, cfg writes are taken.
`default_nettype none

module kmer_suffix_bucketing_core #(
  parameter int ALPHABET_SIZE = ksb_pkg::KSB_ALPHABET_SIZE,
  parameter int MAX_WINDOW    = ksb_pkg::KSB_MAX_WINDOW,
  parameter int SLOT_DEPTH    = ksb_pkg::KSB_SLOT_DEPTH,
  parameter int POSITION_BITS = ksb_pkg::KSB_POSITION_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  ksb_pkg::ksb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ksb_pkg::ksb_out_t out_data
);

  import ksb_pkg::*;

  ksb_cmd_t  cmd;
  ksb_stat_t stat;

  // Sequencing.
  ksb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Window hashing, memories and result register.
  ksb_datapath #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_WINDOW    (MAX_WINDOW),
    .SLOT_DEPTH    (SLOT_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

### bench/kmer_suffix_bucketing_core_test.sv
// Self-checking testbench of the k-mer suffix bucketing core: a stimulus table, then random
// letter streams, bucket reads and slot reads checked against an in-bench bucket index model.
// Depends on ksb_pkg and kmer_suffix_bucketing_core.
`default_nettype none

module kmer_suffix_bucketing_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ksb_pkg::*;

  localparam int ALPHA    = KSB_ALPHABET_SIZE;
  localparam int MAXW     = KSB_MAX_WINDOW;
  localparam int BUCKETS  = 17576;
  localparam int SLOTS    = 65536;
  localparam int WATCHDOG_LIMIT = 80000;
  localparam int REPORT_CAP     = 200;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    ksb_in_t  item;
    bit       typed;
    ksb_out_t result;
  } stim_row_t;

  logic     clk;
  logic     rst;
  logic     cfg_valid;
  logic     cfg_ready;
  logic [1:0] cfg_data;
  logic     in_valid;
  logic     in_ready;
  ksb_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  ksb_out_t out_data;

  kmer_suffix_bucketing_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Model state of the bucket index.
  logic [1:0]  k_setting;
  logic [4:0]  win_code [0:MAXW-1];
  int          win_fill;
  logic [15:0] pos_now;
  logic [15:0] seq_now;
  int          free_slot;
  logic [16:0] head_mem [0:BUCKETS-1];
  logic [16:0] count_mem [0:BUCKETS-1];
  logic [15:0] slot_seq_mem [0:SLOTS-1];
  logic [15:0] slot_pos_mem [0:SLOTS-1];
  logic [16:0] slot_link_mem [0:SLOTS-1];

  ksb_out_t  awaited_results [$];
  stim_row_t stim_table [$];
  int        fail_count;
  int        reported;
  int        idle_cycles;
  int        burst_left;
  bit        row_typed;
  ksb_out_t  row_result;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic ksb_in_t item_of(logic [1:0] c, logic [7:0] s, logic l, logic [15:0] ix);
    ksb_in_t it;
    it.cmd = c;
    it.symbol = s;
    it.last_in_sequence = l;
    it.read_index = ix;
    return it;
  endfunction

  function automatic ksb_out_t out_of(logic [2:0] st, int bn, int sn, logic [16:0] ln, int ct,
                                      int sq, int sp);
    ksb_out_t r;
    r.status = st;
    r.bucket_number = 15'(bn);
    r.slot_number = 16'(sn);
    r.link_slot = ln;
    r.bucket_count = 17'(ct);
    r.sequence_number = 16'(sq);
    r.start_position = 16'(sp);
    return r;
  endfunction

  function automatic int eff_window();
    if (k_setting == 2'd0) return 1;
    if (int'(k_setting) > MAXW) return MAXW;
    return int'(k_setting);
  endfunction

  // Number of buckets addressable with the current window length.
  function automatic int bucket_span();
    int p;
    p = 1;
    for (int i = 0; i < eff_window(); i++) p = p * ALPHA;
    return p;
  endfunction

  function automatic logic [7:0] bad_symbol();
    int r;
    r = $urandom_range(0, 255 - ALPHA);
    return (r < int'(LETTER_BASE)) ? 8'(r) : 8'(r + ALPHA);
  endfunction

  // Returns the result of one transaction and advances the model state.
  function automatic ksb_out_t index_result(ksb_in_t it);
    ksb_out_t r;
    int k, sym, b, cnt;
    logic [15:0] start;
    logic [16:0] head;
    r = '0;
    r.link_slot = LINK_NONE;
    k = eff_window();
    case (it.cmd)
      CMD_PUSH: begin
        sym = int'(it.symbol);
        r.sequence_number = seq_now;
        if (sym < int'(LETTER_BASE) || sym - int'(LETTER_BASE) >= ALPHA) begin
          win_fill = 0;
          r.status = ST_BAD;
        end else begin
          for (int i = 0; i < MAXW - 1; i++) win_code[i] = win_code[i+1];
          win_code[MAXW-1] = 5'(sym - int'(LETTER_BASE));
          if (win_fill < MAXW) win_fill++;
          if (win_fill >= k && !it.last_in_sequence) begin
            b = 0;
            for (int i = MAXW - k; i < MAXW; i++) b = b * ALPHA + int'(win_code[i]);
            start = pos_now - 16'(k - 1);
            head = head_mem[b];
            cnt = int'(count_mem[b]);
            r.bucket_number = 15'(b);
            r.start_position = start;
            if (free_slot >= SLOTS) begin
              r.status = ST_FULL;
              r.link_slot = head;
              r.bucket_count = 17'(cnt);
            end else begin
              slot_seq_mem[free_slot] = seq_now;
              slot_pos_mem[free_slot] = start;
              slot_link_mem[free_slot] = head;
              head_mem[b] = 17'(free_slot);
              if (17'(cnt) < COUNT_MAX) cnt++;
              count_mem[b] = 17'(cnt);
              r.status = ST_INSERTED;
              r.slot_number = 16'(free_slot);
              r.link_slot = head;
              r.bucket_count = 17'(cnt);
              free_slot++;
            end
          end else begin
            r.status = ST_NO_WINDOW;
          end
        end
        // The end of a sequence clears the window and opens the next sequence.
        if (it.last_in_sequence) begin
          win_fill = 0;
          pos_now = '0;
          seq_now = seq_now + 16'd1;
        end else begin
          pos_now = pos_now + 16'd1;
        end
      end
      CMD_READ_BUCKET: begin
        if (int'(it.read_index) < bucket_span()) begin
          r.status = ST_READ_OK;
          r.bucket_number = 15'(it.read_index);
          r.link_slot = head_mem[it.read_index];
          r.bucket_count = count_mem[it.read_index];
        end else begin
          r.status = ST_RANGE;
          r.bucket_number = 15'(it.read_index);
        end
      end
      CMD_READ_SLOT: begin
        r.slot_number = it.read_index;
        if (int'(it.read_index) < free_slot) begin
          r.status = ST_READ_OK;
          r.link_slot = slot_link_mem[it.read_index];
          r.sequence_number = slot_seq_mem[it.read_index];
          r.start_position = slot_pos_mem[it.read_index];
        end else begin
          r.status = ST_RANGE;
        end
      end
      default: begin
        r.status = ST_NO_WINDOW;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      fail_count++;
      if (reported < REPORT_CAP) begin
        reported++;
        $error("%s: expected %0d, actual %0d", name, want, got);
      end
    end
  endfunction

  // Monitor: compares results, then records the expectation of a new input transaction.
  always @(posedge clk) begin
    ksb_out_t want;
    ksb_out_t got;
    bit moved;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      moved = 1'b0;
      if (cfg_valid && cfg_ready) begin
        k_setting = cfg_data;
        moved = 1'b1;
      end
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (awaited_results.size() == 0) begin
          fail_count++;
          if (reported < REPORT_CAP) begin
            reported++;
            $error("result transaction with no expectation waiting");
          end
        end else begin
          want = awaited_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("bucket_number", want.bucket_number, out_data.bucket_number);
          check_field("slot_number", want.slot_number, out_data.slot_number);
          check_field("link_slot", want.link_slot, out_data.link_slot);
          check_field("bucket_count", want.bucket_count, out_data.bucket_count);
          check_field("sequence_number", want.sequence_number, out_data.sequence_number);
          check_field("start_position", want.start_position, out_data.start_position);
        end
      end
      if (in_valid && in_ready) begin
        moved = 1'b1;
        got = index_result(in_data);
        awaited_results.push_back(row_typed ? row_result : got);
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  // Watchdog on cycles with no transaction on any channel.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Receiver: ready runs of random length broken by short stalls.
  initial begin
    int run;
    int stall;
    out_ready = 1'b0;
    forever begin
      run = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      @(negedge clk);
      out_ready <= 1'b1;
      repeat (run - 1) @(negedge clk);
      stall = $urandom_range(1, 10);
      @(negedge clk);
      out_ready <= 1'b0;
      repeat (stall - 1) @(negedge clk);
    end
  end

  // Sends one input transaction, opening a random gap, possibly none, before each new burst.
  task automatic send_item(ksb_in_t it, bit typed, ksb_out_t result);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 32);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    row_typed <= typed;
    row_result <= result;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic end_burst();
    @(negedge clk);
    in_valid <= 1'b0;
    row_typed <= 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes the window length once the block has gone quiet.
  task automatic write_window(logic [1:0] v);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic table_row(ksb_in_t it, bit typed, ksb_out_t result);
    stim_row_t row;
    row.item = it;
    row.typed = typed;
    row.result = result;
    stim_table.push_back(row);
  endtask

  // Random traffic: mostly well-formed letter sequences, plus reads and noise.
  task automatic run_mixed(int n_items);
    int sent, pick, len, span;
    logic [7:0] sym;
    logic [15:0] ix;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = $urandom_range(1, 10);
        span = $urandom_range(0, 1) ? ALPHA : $urandom_range(2, 3);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 14) == 0) sym = bad_symbol();
          else sym = LETTER_BASE + 8'($urandom_range(0, span - 1));
          send_item(item_of(CMD_PUSH, sym, j == len - 1, 16'($urandom)), 1'b0, '0);
        end
        sent += len;
      end else begin
        if (pick < 80) begin
          ix = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, bucket_span()));
          send_item(item_of(CMD_READ_BUCKET, 8'($urandom), 1'($urandom), ix), 1'b0, '0);
        end else if (pick < 92) begin
          ix = ($urandom_range(0, 3) == 0 || free_slot == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, free_slot));
          send_item(item_of(CMD_READ_SLOT, 8'($urandom), 1'($urandom), ix), 1'b0, '0);
        end else if (pick < 96) begin
          send_item(item_of(CMD_PUSH, 8'($urandom), 1'($urandom), 16'($urandom)), 1'b0, '0);
        end else begin
          send_item(item_of(CMD_UNUSED, 8'($urandom), 1'($urandom), 16'($urandom)), 1'b0, '0);
        end
        sent++;
      end
    end
    end_burst();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    row_typed = 1'b0;
    row_result = '0;
    fail_count = 0;
    reported = 0;
    idle_cycles = 0;
    burst_left = 0;

    // Model state after reset.
    k_setting = KMER_LEN_RESET;
    for (int i = 0; i < MAXW; i++) win_code[i] = '0;
    win_fill = 0;
    pos_now = '0;
    seq_now = '0;
    free_slot = 0;
    for (int i = 0; i < BUCKETS; i++) begin
      head_mem[i] = LINK_NONE;
      count_mem[i] = '0;
    end

    // Directed rows: reads of an empty table, range limits, bad letters, then a few windows.
    table_row(item_of(CMD_READ_BUCKET, 8'h00, 1'b0, 16'd0), 1'b1,
              out_of(ST_READ_OK, 0, 0, LINK_NONE, 0, 0, 0));
    table_row(item_of(CMD_READ_BUCKET, 8'hFF, 1'b1, 16'd17575), 1'b1,
              out_of(ST_READ_OK, 17575, 0, LINK_NONE, 0, 0, 0));
    table_row(item_of(CMD_READ_BUCKET, 8'h00, 1'b0, 16'd17576), 1'b1,
              out_of(ST_RANGE, 17576, 0, LINK_NONE, 0, 0, 0));
    table_row(item_of(CMD_READ_BUCKET, 8'h00, 1'b0, 16'hFFFF), 1'b1,
              out_of(ST_RANGE, 15'h7FFF, 0, LINK_NONE, 0, 0, 0));
    table_row(item_of(CMD_READ_SLOT, 8'h00, 1'b0, 16'd0), 1'b1,
              out_of(ST_RANGE, 0, 0, LINK_NONE, 0, 0, 0));
    table_row(item_of(CMD_READ_SLOT, 8'hFF, 1'b1, 16'hFFFF), 1'b1,
              out_of(ST_RANGE, 0, 16'hFFFF, LINK_NONE, 0, 0, 0));
    table_row(item_of(CMD_UNUSED, 8'hFF, 1'b1, 16'hFFFF), 1'b1,
              out_of(ST_NO_WINDOW, 0, 0, LINK_NONE, 0, 0, 0));
    table_row(item_of(CMD_PUSH, 8'h00, 1'b0, 16'd0), 1'b1,
              out_of(ST_BAD, 0, 0, LINK_NONE, 0, 0, 0));
    table_row(item_of(CMD_PUSH, 8'hFF, 1'b0, 16'hFFFF), 1'b1,
              out_of(ST_BAD, 0, 0, LINK_NONE, 0, 0, 0));
    table_row(item_of(CMD_PUSH, LETTER_BASE - 8'd1, 1'b0, 16'd0), 1'b1,
              out_of(ST_BAD, 0, 0, LINK_NONE, 0, 0, 0));
    table_row(item_of(CMD_PUSH, LETTER_BASE + 8'(ALPHA), 1'b0, 16'd0), 1'b1,
              out_of(ST_BAD, 0, 0, LINK_NONE, 0, 0, 0));
    for (int i = 0; i < 3; i++) table_row(item_of(CMD_PUSH, LETTER_BASE, 1'b0, 16'd0), 1'b0, '0);
    for (int i = 0; i < 3; i++)
      table_row(item_of(CMD_PUSH, LETTER_BASE + 8'(ALPHA - 1), 1'b0, 16'd0), 1'b0, '0);
    // A window that completes on the last letter inserts nothing.
    table_row(item_of(CMD_PUSH, LETTER_BASE + 8'(ALPHA - 1), 1'b1, 16'd0), 1'b0, '0);
    // A one-letter sequence.
    table_row(item_of(CMD_PUSH, LETTER_BASE, 1'b1, 16'd0), 1'b0, '0);
    table_row(item_of(CMD_READ_BUCKET, 8'h00, 1'b0, 16'd0), 1'b0, '0);
    table_row(item_of(CMD_READ_BUCKET, 8'h00, 1'b0, 16'd17575), 1'b0, '0);
    table_row(item_of(CMD_READ_SLOT, 8'h00, 1'b0, 16'd0), 1'b0, '0);
    table_row(item_of(CMD_READ_SLOT, 8'h00, 1'b0, 16'd1), 1'b0, '0);
    table_row(item_of(CMD_READ_SLOT, 8'h00, 1'b0, 16'd2), 1'b0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) send_item(stim_table[i].item, stim_table[i].typed,
                                      stim_table[i].result);
    end_burst();

    // Random phases over the window lengths, zero clamping to one.
    write_window(2'd1);
    run_mixed(400);
    write_window(2'd2);
    run_mixed(400);
    write_window(2'd0);
    run_mixed(300);
    write_window(2'd3);
    run_mixed(400);

    // A short closing phase back at one-letter windows.
    write_window(2'd1);
    run_mixed(200);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
